// File: rtl/ggph_pkg.sv
// Package for the geographic grid point histogram.
// Holds grid and count sizes, coordinate constants, and controller/datapath types.
// No dependencies.
package ggph_pkg;

  // Grid geometry and counter size
  localparam int unsigned GRID_SIZE  = 256;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned GRID_BITS  = $clog2(GRID_SIZE);
  localparam int unsigned ADDR_BITS  = 2 * GRID_BITS;
  localparam int unsigned DEPTH      = GRID_SIZE * GRID_SIZE;

  // Grid extent in minutes of arc
  localparam int unsigned LAT_SOUTH = 600;
  localparam int unsigned LAT_SPAN  = 2160;
  localparam int unsigned LON_WEST  = 7320;
  localparam int unsigned LON_SPAN  = 1920;

  // DDMM to minutes: degrees = (v * DDMM_RECIP) >> DDMM_SHIFT, exact for v < 2^15
  localparam int unsigned DDMM_BITS      = 15;
  localparam int unsigned DDMM_RECIP     = 5243;
  localparam int unsigned DDMM_RECIP_BITS = 13;
  localparam int unsigned DDMM_SHIFT     = 19;
  localparam int unsigned DDMM_PROD_BITS = DDMM_BITS + DDMM_RECIP_BITS;
  localparam int unsigned DEG_BITS       = DDMM_PROD_BITS - DDMM_SHIFT;
  localparam int unsigned DDMM_DEG_SCALE = 100;
  localparam int unsigned MIN_PER_DEG    = 60;
  localparam int unsigned MIN_BITS       = 15;

  // Cell quotient by reciprocal multiply: q = (offset * RECIP) >> SHIFT
  // equals trunc(offset * GRID_SIZE / span) for every offset a DDMM field can give
  localparam int unsigned OFS_BITS  = 14;
  localparam int unsigned X_SHIFT   = 18;
  localparam int unsigned Y_SHIFT   = 20;
  localparam int unsigned X_RECIP   = ((2 ** X_SHIFT) * GRID_SIZE + LON_SPAN - 1) / LON_SPAN;
  localparam int unsigned Y_RECIP   = ((2 ** Y_SHIFT) * GRID_SIZE + LAT_SPAN - 1) / LAT_SPAN;
  localparam int unsigned PROD_BITS = 31;
  localparam int unsigned QUO_BITS  = 11;

  // Action codes
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MINS,
    S_DIVX,
    S_WAITX,
    S_WAITY,
    S_LOOKUP,
    S_DONE
  } ggph_state_e;

  typedef struct packed {
    logic load;       // latch input item
    logic mins;       // form minutes and grid offsets
    logic div_start;  // launch quotient unit
    logic div_sel_y;  // quotient unit works on latitude
    logic cap_x;      // capture column from quotient
    logic cap_y;      // capture row from quotient
    logic lookup;     // form cell address, issue memory read
    logic finish;     // write back and load output register
    logic clear_we;   // clearing pass write
  } ggph_cmd_t;

  typedef struct packed {
    logic act_read;
    logic div_done;
    logic out_free;
    logic clear_last;
  } ggph_status_t;

endpackage

// File: rtl/ggph_div.sv
// Quotient unit for column and row: reciprocal multiply by the span, one registered stage.
// Depends on ggph_pkg for operand widths and reciprocal constants.
module ggph_div import ggph_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                sel_y_i,
  input  logic [OFS_BITS-1:0] dividend_i,
  output logic                done_o,
  output logic [QUO_BITS-1:0] quotient_o
);

  logic                 done_q;
  logic                 sel_y_q;
  logic [PROD_BITS-1:0] prod_d, prod_q;

  // Offset times the scaled reciprocal of the selected span
  always_comb begin
    prod_d = PROD_BITS'(dividend_i)
           * (sel_y_i ? PROD_BITS'(Y_RECIP) : PROD_BITS'(X_RECIP));
  end

  // Done is registered and rises in the cycle after launch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  // Product register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q  <= prod_d;
      sel_y_q <= sel_y_i;
    end
  end

  // Drop the fraction bits
  assign quotient_o = sel_y_q ? prod_q[Y_SHIFT +: QUO_BITS] : prod_q[X_SHIFT +: QUO_BITS];
  assign done_o     = done_q;

endmodule

// File: rtl/ggph_dp.sv
// Datapath: DDMM conversion, cell binning through the shared quotient unit,
// count memory with clearing pass, and output register. Uses ggph_pkg, ggph_div.
module ggph_dp import ggph_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ggph_cmd_t    cmd_i,
  output ggph_status_t status_o,
  input  logic         action_i,
  input  logic [13:0]  lat_ddmm_i,
  input  logic [14:0]  lon_ddmm_i,
  input  logic [7:0]   read_x_i,
  input  logic [7:0]   read_y_i,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic         in_range_o,
  output logic [7:0]   cell_x_o,
  output logic [7:0]   cell_y_o,
  output logic [15:0]  count_o
);

  // Input item registers
  logic                 act_q;
  logic [DDMM_BITS-1:0] lat_v_q, lon_v_q;
  logic [DEG_BITS-1:0]  lat_deg_q, lon_deg_q;
  logic [7:0]           rx_q, ry_q;

  logic [DDMM_PROD_BITS-1:0] lat_prod, lon_prod;

  // Degrees by reciprocal multiply on the incoming fields
  always_comb begin
    lat_prod = DDMM_PROD_BITS'(lat_ddmm_i) * DDMM_PROD_BITS'(DDMM_RECIP);
    lon_prod = DDMM_PROD_BITS'(lon_ddmm_i) * DDMM_PROD_BITS'(DDMM_RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q     <= action_i;
      lat_v_q   <= DDMM_BITS'(lat_ddmm_i);
      lon_v_q   <= lon_ddmm_i;
      lat_deg_q <= lat_prod[DDMM_PROD_BITS-1:DDMM_SHIFT];
      lon_deg_q <= lon_prod[DDMM_PROD_BITS-1:DDMM_SHIFT];
      rx_q      <= read_x_i;
      ry_q      <= read_y_i;
    end
  end

  // Total minutes and grid offsets
  logic [MIN_BITS-1:0] lat_dg, lon_dg, lat_min, lon_min, lon_mag;
  logic                lon_neg_d, lat_low_d;
  logic [OFS_BITS-1:0] lat_ofs_q, lon_ofs_q;
  logic                lon_neg_q, lat_low_q;

  always_comb begin
    lat_dg    = MIN_BITS'(lat_deg_q);
    lon_dg    = MIN_BITS'(lon_deg_q);
    lat_min   = lat_dg * MIN_BITS'(MIN_PER_DEG)
              + (MIN_BITS'(lat_v_q) - lat_dg * MIN_BITS'(DDMM_DEG_SCALE));
    lon_min   = lon_dg * MIN_BITS'(MIN_PER_DEG)
              + (MIN_BITS'(lon_v_q) - lon_dg * MIN_BITS'(DDMM_DEG_SCALE));
    lon_neg_d = (lon_min < MIN_BITS'(LON_WEST));
    lon_mag   = lon_neg_d ? (MIN_BITS'(LON_WEST) - lon_min)
                          : (lon_min - MIN_BITS'(LON_WEST));
    lat_low_d = (lat_min <= MIN_BITS'(LAT_SOUTH));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mins) begin
      lon_neg_q <= lon_neg_d;
      lat_low_q <= lat_low_d;
      lon_ofs_q <= OFS_BITS'(lon_mag);
      lat_ofs_q <= lat_low_d ? '0 : OFS_BITS'(lat_min - MIN_BITS'(LAT_SOUTH));
    end
  end

  // Shared quotient unit for column and row
  logic                div_done;
  logic [QUO_BITS-1:0] quo;
  logic [OFS_BITS-1:0] div_num;

  assign div_num = cmd_i.div_sel_y ? lat_ofs_q : lon_ofs_q;

  ggph_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .sel_y_i    (cmd_i.div_sel_y),
    .dividend_i (div_num),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Column: truncation toward zero, so a small negative offset still lands on 0
  // Row: GRID_SIZE minus quotient, quotient must be 1..GRID_SIZE
  logic [GRID_BITS-1:0] x_q, y_q;
  logic                 x_ok_q, y_ok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_x) begin
      x_q    <= GRID_BITS'(quo);
      x_ok_q <= (quo < QUO_BITS'(GRID_SIZE)) && (!lon_neg_q || (quo == '0));
    end
    if (cmd_i.cap_y) begin
      y_q    <= GRID_BITS'(QUO_BITS'(GRID_SIZE) - quo);
      y_ok_q <= !lat_low_q && (quo != '0) && (quo <= QUO_BITS'(GRID_SIZE));
    end
  end

  // Cell selection for add or read
  logic [GRID_BITS-1:0] cx_d, cy_d, cx_q, cy_q;
  logic                 ok_d, ok_q;
  logic [ADDR_BITS-1:0] addr_d, addr_q;

  always_comb begin
    if (act_q == ACT_READ) begin
      cx_d = GRID_BITS'(rx_q);
      cy_d = GRID_BITS'(ry_q);
      ok_d = (int'(rx_q) < GRID_SIZE) && (int'(ry_q) < GRID_SIZE);
    end else begin
      cx_d = x_q;
      cy_d = y_q;
      ok_d = x_ok_q && y_ok_q;
    end
    addr_d = ADDR_BITS'(cx_d) * ADDR_BITS'(GRID_SIZE) + ADDR_BITS'(cy_d);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      ok_q   <= ok_d;
      addr_q <= addr_d;
    end
  end

  // Clearing pass address counter
  logic [ADDR_BITS-1:0] clr_q;
  logic                 clr_last;

  assign clr_last = (clr_q == ADDR_BITS'(DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_we && !clr_last) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Count memory, registered read
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_q;
  logic [COUNT_BITS-1:0] new_cnt;
  logic                  upd;
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  // Saturating increment for an add
  always_comb begin
    upd       = (act_q == ACT_ADD) && ok_q;
    new_cnt   = (upd && (rd_q != '1)) ? rd_q + 1'b1 : rd_q;
    mem_we    = cmd_i.clear_we || (cmd_i.finish && upd);
    mem_waddr = cmd_i.clear_we ? clr_q : addr_q;
    mem_wdata = cmd_i.clear_we ? '0 : new_cnt;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      rd_q <= mem[addr_d];
    end
  end

  // Output register
  logic        out_valid_q;
  logic        out_in_range_q;
  logic [7:0]  out_x_q, out_y_q;
  logic [15:0] out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_in_range_q <= ok_q;
      out_x_q        <= ok_q ? 8'(cx_q) : '0;
      out_y_q        <= ok_q ? 8'(cy_q) : '0;
      out_count_q    <= ok_q ? 16'(new_cnt) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign in_range_o  = out_in_range_q;
  assign cell_x_o    = out_x_q;
  assign cell_y_o    = out_y_q;
  assign count_o     = out_count_q;

  // Status to the controller
  always_comb begin
    status_o.act_read   = (act_q == ACT_READ);
    status_o.div_done   = div_done;
    status_o.out_free   = !out_valid_q || out_ready_i;
    status_o.clear_last = clr_last;
  end

`ifndef SYNTHESIS
  // A quotient is only reported right after a launch
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> $past(cmd_i.div_start))
    else $error("quotient done without a launch");

  // Result loads only into a free output register
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending output");

  // Out-of-range items give an all-zero result
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && !ok_q) |=>
      (!out_in_range_q && out_x_q == '0 && out_y_q == '0 && out_count_q == '0))
    else $error("out-of-range result not zero");
`endif

endmodule

// File: rtl/ggph_ctrl.sv
// Controller state machine: clearing pass, item sequencing, divider launches.
// Depends on ggph_pkg for the state, command and status types.
module ggph_ctrl import ggph_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ggph_status_t status_i,
  output ggph_cmd_t    cmd_o
);

  ggph_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_we = 1'b1;
        if (status_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MINS;
        end
      end
      S_MINS: begin
        cmd_o.mins = 1'b1;
        state_d    = status_i.act_read ? S_LOOKUP : S_DIVX;
      end
      S_DIVX: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_WAITX;
      end
      S_WAITX: begin
        if (status_i.div_done) begin
          cmd_o.cap_x     = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel_y = 1'b1;
          state_d         = S_WAITY;
        end
      end
      S_WAITY: begin
        cmd_o.div_sel_y = 1'b1;
        if (status_i.div_done) begin
          cmd_o.cap_y = 1'b1;
          state_d     = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/geo_grid_point_histogram_top.sv
// Geographic grid point histogram, top level. Uses ggph_pkg, ggph_ctrl, ggph_dp.
// Add item, from transfer to result: minutes, two reciprocal-multiply
//   passes for column and row, then the registered count-memory read and write-back.
// Read item: the minutes step and the registered count-memory read.
// One item at a time; results load when the output is free, the next is taken while
//   a result waits. Reset: a clearing pass zeroes all 65536 counters, input ready low.
module geo_grid_point_histogram_top import ggph_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [13:0] lat_ddmm_i,
  input  logic [14:0] lon_ddmm_i,
  input  logic [7:0]  read_x_i,
  input  logic [7:0]  read_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        in_range_o,
  output logic [7:0]  cell_x_o,
  output logic [7:0]  cell_y_o,
  output logic [15:0] count_o
);

  ggph_cmd_t    cmd;
  ggph_status_t status;

  ggph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ggph_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .action_i    (action_i),
    .lat_ddmm_i  (lat_ddmm_i),
    .lon_ddmm_i  (lon_ddmm_i),
    .read_x_i    (read_x_i),
    .read_y_i    (read_y_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .in_range_o  (in_range_o),
    .cell_x_o    (cell_x_o),
    .cell_y_o    (cell_y_o),
    .count_o     (count_o)
  );

endmodule

// File: sim/tb.sv
// Testbench for geo_grid_point_histogram_top: drives add and read transfers with
// random bursts and output stalls, and checks each result against an in-bench model.
// Depends on ggph_pkg and the RTL under rtl/.
module tb;
  import ggph_pkg::*;

  localparam int unsigned STALL_LIMIT = 140000;  // covers the clear pass of all 65536 counters
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned RANDOM_ITEMS = 1930;

  typedef struct {
    logic        action;
    logic [13:0] lat;
    logic [14:0] lon;
    logic [7:0]  rx;
    logic [7:0]  ry;
  } point_item_t;

  typedef struct packed {
    logic        in_range;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [15:0] count;
  } cell_result_t;

  // Histogram model and queue of results still owed by the block
  class hist_scoreboard;
    bit [15:0]    cell_count [DEPTH];
    cell_result_t owed_q[$];
    bit [7:0]     hit_x[$];
    bit [7:0]     hit_y[$];
    int unsigned  mismatches;

    function int ddmm_minutes(int v);
      return (v / 100) * 60 + v % 100;
    endfunction

    function void note_item(point_item_t it);
      int lat_m;
      int lon_m;
      int col;
      int row;
      int idx;
      cell_result_t r;
      r = '0;
      if (it.action == ACT_READ) begin
        // 8-bit read coordinates always fall inside a 256 grid
        idx = int'(it.rx) * int'(GRID_SIZE) + int'(it.ry);
        r.in_range = 1'b1;
        r.cell_x   = it.rx;
        r.cell_y   = it.ry;
        r.count    = cell_count[idx];
      end else begin
        lat_m = ddmm_minutes(int'(it.lat));
        lon_m = ddmm_minutes(int'(it.lon));
        // signed division truncates toward zero
        col = ((lon_m - int'(LON_WEST)) * int'(GRID_SIZE)) / int'(LON_SPAN);
        row = int'(GRID_SIZE) - ((lat_m - int'(LAT_SOUTH)) * int'(GRID_SIZE)) / int'(LAT_SPAN);
        if (col >= 0 && col < int'(GRID_SIZE) && row >= 0 && row < int'(GRID_SIZE)) begin
          idx = col * int'(GRID_SIZE) + row;
          if (cell_count[idx] != 16'hFFFF) cell_count[idx]++;
          r.in_range = 1'b1;
          r.cell_x   = col[7:0];
          r.cell_y   = row[7:0];
          r.count    = cell_count[idx];
          hit_x.push_back(col[7:0]);
          hit_y.push_back(row[7:0]);
        end
      end
      owed_q.push_back(r);
    endfunction

    function void check_result(cell_result_t got);
      cell_result_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: in_range=%0d x=%0d y=%0d count=%0d",
                   got.in_range, got.cell_x, got.cell_y, got.count);
        return;
      end
      want = owed_q.pop_front();
      if (got.in_range !== want.in_range || got.cell_x !== want.cell_x ||
          got.cell_y !== want.cell_y || got.count !== want.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want in_range=%0d x=%0d y=%0d count=%0d, got %0d %0d %0d %0d",
                   want.in_range, want.cell_x, want.cell_y, want.count,
                   got.in_range, got.cell_x, got.cell_y, got.count);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        action_i = ACT_ADD;
  logic [13:0] lat_ddmm_i = '0;
  logic [14:0] lon_ddmm_i = '0;
  logic [7:0]  read_x_i = '0;
  logic [7:0]  read_y_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        in_range_o;
  logic [7:0]  cell_x_o;
  logic [7:0]  cell_y_o;
  logic [15:0] count_o;

  hist_scoreboard sb = new();

  geo_grid_point_histogram_top i_dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Offer one item and hold it until the input transfer
  task automatic offer(point_item_t it);
    in_valid_i <= 1'b1;
    action_i   <= it.action;
    lat_ddmm_i <= it.lat;
    lon_ddmm_i <= it.lon;
    read_x_i   <= it.rx;
    read_y_i   <= it.ry;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
  endtask

  task automatic idle_gap(int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop offering until every owed result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.owed_q.size() != 0);
  endtask

  function automatic point_item_t add_item(int lat_v, int lon_v);
    point_item_t it;
    it.action = ACT_ADD;
    it.lat    = lat_v[13:0];
    it.lon    = lon_v[14:0];
    it.rx     = 8'($urandom());
    it.ry     = 8'($urandom());
    return it;
  endfunction

  function automatic point_item_t read_item(int x, int y);
    point_item_t it;
    it.action = ACT_READ;
    it.lat    = 14'($urandom());
    it.lon    = 15'($urandom());
    it.rx     = x[7:0];
    it.ry     = y[7:0];
    return it;
  endfunction

  // Minutes to DDMM with minutes field kept below 60
  function automatic int to_ddmm(int m);
    return (m / 60) * 100 + m % 60;
  endfunction

  function automatic point_item_t random_item();
    int unsigned sel;
    int unsigned k;
    sel = $urandom_range(0, 99);
    if (sel < 35)       // anywhere on the grid, with a margin past its west, east and north edges
      return add_item(to_ddmm($urandom_range(601, 2770)), to_ddmm($urandom_range(7300, 9250)));
    else if (sel < 55)  // small hot spot so counts climb
      return add_item(to_ddmm($urandom_range(2700, 2760)), to_ddmm($urandom_range(7320, 7350)));
    else if (sel < 65)  // minutes field above 59
      return add_item($urandom_range(9, 47) * 100 + $urandom_range(60, 99),
                      $urandom_range(121, 155) * 100 + $urandom_range(60, 99));
    else if (sel < 75)  // raw field values, full width
      return add_item($urandom_range(0, 16383), $urandom_range(0, 32767));
    else if (sel < 88 && sb.hit_x.size() != 0) begin
      k = $urandom_range(0, sb.hit_x.size() - 1);
      return read_item(sb.hit_x[k], sb.hit_y[k]);
    end
    return read_item($urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  // Stimulus
  initial begin
    point_item_t directed_q[$];
    int unsigned burst_left;
    bit          steady;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Grid corners and edges
    directed_q.push_back(add_item(4600, 12200));   // x 0, y 0
    directed_q.push_back(add_item(4600, 12200));   // same cell again
    directed_q.push_back(add_item(1009, 15359));   // x 255, y 255
    directed_q.push_back(add_item(1000, 13000));   // southern edge, out
    directed_q.push_back(add_item(1001, 13000));   // just north of it, still out
    directed_q.push_back(add_item(3000, 15400));   // eastern edge, out
    directed_q.push_back(add_item(3000, 12159));   // west by one minute, truncates to x 0
    directed_q.push_back(add_item(3000, 12000));   // far west, out
    directed_q.push_back(add_item(4601, 13000));   // north of span, still y 0
    directed_q.push_back(add_item(4609, 13000));   // y goes negative, out
    directed_q.push_back(add_item(0, 0));
    directed_q.push_back(add_item(16383, 32767));
    directed_q.push_back(add_item(9059, 18059));
    directed_q.push_back(add_item(1075, 12399));   // minutes field above 59, in grid
    directed_q.push_back(add_item(4699, 13000));   // minutes field above 59, out
    directed_q.push_back(read_item(0, 0));
    directed_q.push_back(read_item(255, 255));
    directed_q.push_back(read_item(0, 255));
    directed_q.push_back(read_item(255, 0));
    directed_q.push_back(read_item(0, 114));
    directed_q.push_back(read_item(170, 37));
    foreach (directed_q[i]) offer(directed_q[i]);
    drain();

    // Random bursts; saturation would need 65535 adds to one cell, beyond this run
    burst_left = $urandom_range(1, 24);
    steady = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain();
      offer(random_item());
      burst_left--;
      if (burst_left == 0) begin
        if (!steady) idle_gap($urandom_range(1, 12));
        burst_left = $urandom_range(1, 24);
        steady = ($urandom_range(0, 3) == 0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Result side: check each transfer, stall on a changing pattern
  initial begin
    int unsigned  mode;
    int unsigned  mode_left;
    int unsigned  hold_left;
    int unsigned  seen;
    int unsigned  phase;
    cell_result_t got;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    seen = 0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = {in_range_o, cell_x_o, cell_y_o, count_o};
        sb.check_result(got);
        seen++;
        // long hold-off so the block backs up into its input
        if (seen == 300 || seen == 1200) hold_left = 600;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      phase++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 9) < 7);
          2: out_ready_i <= ($urandom_range(0, 9) < 2);
          default: out_ready_i <= (phase % 4 == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/ggph_pkg.sv
rtl/ggph_div.sv
rtl/ggph_dp.sv
rtl/ggph_ctrl.sv
rtl/geo_grid_point_histogram_top.sv
sim/tb.sv
